[rtl/core/pcg32_bounded_random_assert.svh]
// ----------------------------------------------------------------------------
// pcg32_bounded_random_assert.svh
// Assertion macros used by the checker of the bounded random block.
// ----------------------------------------------------------------------------
`ifndef PCG32_BOUNDED_RANDOM_ASSERT_SVH
`define PCG32_BOUNDED_RANDOM_ASSERT_SVH

// Checked on every rising edge outside reset.
`define PCGB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define PCGB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/core/pcgb_pkg.sv]
// ----------------------------------------------------------------------------
// pcgb_pkg
// Widths, constants and the output permutation of the bounded PCG generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pcgb_pkg;

  localparam int STATE_W = 64;            // generator state and draw width
  localparam int WORD_W  = 32;            // generator output and bound width
  localparam int SPAN_W  = WORD_W + 1;    // range, up to 2^32
  localparam int CNT_W   = $clog2(STATE_W);
  localparam int CFG_IDX_W = 1;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STATE_W - 1);

  localparam logic [STATE_W-1:0] LCG_MUL = 64'd6364136223846793005;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SEED_STATE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEED_STREAM = 1'd1;

  // XSH-RR output permutation of the old state
  function automatic logic [WORD_W-1:0] xsh_rr(input logic [STATE_W-1:0] s);
    logic [STATE_W-1:0] x;
    logic [WORD_W-1:0]  mixed;
    logic [4:0]         rot;
    x     = ((s >> 18) ^ s) >> 27;
    mixed = x[WORD_W-1:0];
    rot   = s[63:59];
    return (mixed >> rot) | (mixed << (5'd0 - rot));
  endfunction

endpackage

`default_nettype wire

[rtl/core/pcgb_lcg_mul.sv]
// ----------------------------------------------------------------------------
// pcgb_lcg_mul
// Bit-serial LCG step: result = state * LCG_MUL + inc, one multiplier bit
// per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcgb_lcg_mul (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [pcgb_pkg::STATE_W-1:0] state_in,
  input  wire logic [pcgb_pkg::STATE_W-1:0] inc_in,
  output logic                              done,
  output logic [pcgb_pkg::STATE_W-1:0]      result
);

  logic                              busy_r;
  logic                              done_r;
  logic [pcgb_pkg::CNT_W-1:0]        cnt_r;
  logic [pcgb_pkg::STATE_W-1:0]      acc_r;
  logic [pcgb_pkg::STATE_W-1:0]      mcand_r;
  logic [pcgb_pkg::STATE_W-1:0]      mplier_r;

  // Shift-and-add; accumulator starts at the increment
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r   <= 1'b1;
        cnt_r    <= '0;
        acc_r    <= inc_in;
        mcand_r  <= pcgb_pkg::LCG_MUL;
        mplier_r <= state_in;
      end else if (busy_r) begin
        if (mplier_r[0]) begin
          acc_r <= acc_r + mcand_r;
        end
        mcand_r  <= mcand_r << 1;
        mplier_r <= mplier_r >> 1;
        cnt_r    <= cnt_r + 1'b1;
        if (cnt_r == pcgb_pkg::CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

`default_nettype wire

[rtl/core/pcgb_rem.sv]
// ----------------------------------------------------------------------------
// pcgb_rem
// Bit-serial restoring remainder: 64-bit dividend modulo a 33-bit divisor,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcgb_rem (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [pcgb_pkg::STATE_W-1:0] dividend,
  input  wire logic [pcgb_pkg::SPAN_W-1:0]  divisor,
  output logic                              done,
  output logic [pcgb_pkg::SPAN_W-1:0]       remainder
);

  logic                              busy_r;
  logic                              done_r;
  logic [pcgb_pkg::CNT_W-1:0]        cnt_r;
  logic [pcgb_pkg::SPAN_W-1:0]       rem_r;
  logic [pcgb_pkg::SPAN_W-1:0]       dvs_r;
  logic [pcgb_pkg::STATE_W-1:0]      dvd_r;
  logic [pcgb_pkg::SPAN_W:0]         trial;
  logic [pcgb_pkg::SPAN_W:0]         diff;

  // Shift in the next dividend bit, subtract when it fits
  assign trial = {rem_r, dvd_r[pcgb_pkg::STATE_W-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        dvd_r  <= dividend;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        if (trial >= {1'b0, dvs_r}) begin
          rem_r <= diff[pcgb_pkg::SPAN_W-1:0];
        end else begin
          rem_r <= trial[pcgb_pkg::SPAN_W-1:0];
        end
        dvd_r <= dvd_r << 1;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == pcgb_pkg::CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

[rtl/core/pcg32_bounded_random.sv]
// Sequence: invalid or equal bounds pass S_CHECK and S_OUT to the output register;
//   a range adds the limit modulo, two LCG steps and the test per draw, and the
//   final modulo; a rejected draw repeats the draw; the first request after
//   reset first seeds the generator with two LCG steps.
// Throughput: one request at a time, taken once the last result has registered.
// Reset: synchronous active-low rst_n clears control, seeds and generator.
// ----------------------------------------------------------------------------
// pcg32_bounded_random
// PCG XSH-RR 64/32 generator answering signed inclusive-range requests by
// rejection sampling on 64-bit draws built from two outputs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcg32_bounded_random (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // request channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic signed [31:0]             in_low_bound,
  input  wire logic signed [31:0]             in_high_bound,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [31:0]                  out_value,
  output logic                                out_invalid,
  // configuration channel
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [pcgb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]                    cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEED_A_GO,
    S_SEED_A_WAIT,
    S_SEED_B_GO,
    S_SEED_B_WAIT,
    S_CHECK,
    S_LIM_WAIT,
    S_HI_GO,
    S_HI_WAIT,
    S_LO_GO,
    S_LO_WAIT,
    S_TEST,
    S_MOD_WAIT,
    S_OUT
  } state_t;

  state_t                            state_r;
  logic                              seeded_r;
  logic [pcgb_pkg::STATE_W-1:0]      gen_state_r;
  logic [pcgb_pkg::STATE_W-1:0]      seed_state_r;
  logic [pcgb_pkg::STATE_W-1:0]      seed_stream_r;
  logic signed [pcgb_pkg::WORD_W-1:0] lo_r;
  logic signed [pcgb_pkg::WORD_W-1:0] hi_r;
  logic [pcgb_pkg::SPAN_W-1:0]       limit_r;
  logic [pcgb_pkg::STATE_W-1:0]      draw_r;
  logic [pcgb_pkg::WORD_W-1:0]       res_value_r;
  logic                              res_invalid_r;
  logic                              out_valid_r;
  logic [pcgb_pkg::WORD_W-1:0]       out_value_r;
  logic                              out_invalid_r;

  logic [pcgb_pkg::SPAN_W-1:0]       span;
  logic [pcgb_pkg::STATE_W-1:0]      inc;
  logic [pcgb_pkg::WORD_W-1:0]       gen_word;
  logic                              draw_ok;
  logic                              mul_start;
  logic                              mul_done;
  logic [pcgb_pkg::STATE_W-1:0]      mul_result;
  logic                              rem_start;
  logic                              rem_done;
  logic [pcgb_pkg::STATE_W-1:0]      rem_dividend;
  logic [pcgb_pkg::SPAN_W-1:0]       rem_result;

  // Range hi - lo + 1 in 33 bits; only used when hi > lo
  assign span = {hi_r[pcgb_pkg::WORD_W-1], hi_r} - {lo_r[pcgb_pkg::WORD_W-1], lo_r}
                + pcgb_pkg::SPAN_W'(1);
  assign inc      = seed_stream_r | pcgb_pkg::STATE_W'(1);
  assign gen_word = pcgb_pkg::xsh_rr(gen_state_r);
  assign draw_ok  = (draw_r >= pcgb_pkg::STATE_W'(limit_r));

  // Unit launches
  assign mul_start = (state_r == S_SEED_A_GO) || (state_r == S_SEED_B_GO) ||
                     (state_r == S_HI_GO) || (state_r == S_LO_GO);
  assign rem_start = ((state_r == S_CHECK) && (hi_r > lo_r)) ||
                     ((state_r == S_TEST) && draw_ok);
  // limit = (2^64 - span) mod span, then draw mod span
  assign rem_dividend = (state_r == S_CHECK) ?
                        (pcgb_pkg::STATE_W'(0) - pcgb_pkg::STATE_W'(span)) : draw_r;

  pcgb_lcg_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mul_start),
    .state_in (gen_state_r),
    .inc_in   (inc),
    .done     (mul_done),
    .result   (mul_result)
  );

  pcgb_rem u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (rem_start),
    .dividend  (rem_dividend),
    .divisor   (span),
    .done      (rem_done),
    .remainder (rem_result)
  );

  // Sequencer, configuration registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      seeded_r      <= 1'b0;
      gen_state_r   <= '0;
      seed_state_r  <= '0;
      seed_stream_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_valid) begin
        case (cfg_index)
          pcgb_pkg::REG_SEED_STATE:  seed_state_r  <= cfg_data;
          pcgb_pkg::REG_SEED_STREAM: seed_stream_r <= cfg_data;
          default: ;
        endcase
      end

      // result taken downstream; S_OUT handles its own reload
      if (out_valid_r && !out_stall && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            lo_r <= in_low_bound;
            hi_r <= in_high_bound;
            if (!seeded_r) begin
              gen_state_r <= '0;
              state_r     <= S_SEED_A_GO;
            end else begin
              state_r <= S_CHECK;
            end
          end
        end
        S_SEED_A_GO: state_r <= S_SEED_A_WAIT;
        S_SEED_A_WAIT: begin
          if (mul_done) begin
            gen_state_r <= mul_result + seed_state_r;
            state_r     <= S_SEED_B_GO;
          end
        end
        S_SEED_B_GO: state_r <= S_SEED_B_WAIT;
        S_SEED_B_WAIT: begin
          if (mul_done) begin
            gen_state_r <= mul_result;
            seeded_r    <= 1'b1;
            state_r     <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (hi_r < lo_r) begin
            res_value_r   <= '1;
            res_invalid_r <= 1'b1;
            state_r       <= S_OUT;
          end else if (hi_r == lo_r) begin
            res_value_r   <= lo_r;
            res_invalid_r <= 1'b0;
            state_r       <= S_OUT;
          end else begin
            state_r <= S_LIM_WAIT;
          end
        end
        S_LIM_WAIT: begin
          if (rem_done) begin
            limit_r <= rem_result;
            state_r <= S_HI_GO;
          end
        end
        // upper word comes from the first output
        S_HI_GO: begin
          draw_r[63:32] <= gen_word;
          state_r       <= S_HI_WAIT;
        end
        S_HI_WAIT: begin
          if (mul_done) begin
            gen_state_r <= mul_result;
            state_r     <= S_LO_GO;
          end
        end
        S_LO_GO: begin
          draw_r[31:0] <= gen_word;
          state_r      <= S_LO_WAIT;
        end
        S_LO_WAIT: begin
          if (mul_done) begin
            gen_state_r <= mul_result;
            state_r     <= S_TEST;
          end
        end
        // reject draws below the limit
        S_TEST: begin
          if (draw_ok) begin
            state_r <= S_MOD_WAIT;
          end else begin
            state_r <= S_HI_GO;
          end
        end
        S_MOD_WAIT: begin
          if (rem_done) begin
            res_value_r   <= lo_r + rem_result[pcgb_pkg::WORD_W-1:0];
            res_invalid_r <= 1'b0;
            state_r       <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r   <= 1'b1;
            out_value_r   <= res_value_r;
            out_invalid_r <= res_invalid_r;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall    = (state_r != S_IDLE);
  assign cfg_ready   = 1'b1;
  assign out_valid   = out_valid_r;
  assign out_value   = out_value_r;
  assign out_invalid = out_invalid_r;

endmodule

`default_nettype wire

[rtl/core/pcg32_bounded_random_checker.sv]
// ----------------------------------------------------------------------------
// pcg32_bounded_random_checker
// Port-level checks of the bounded random block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "pcg32_bounded_random_assert.svh"

module pcg32_bounded_random_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [31:0] out_value,
  input wire logic               out_invalid
);

  // A pending result stays until taken
  `PCGB_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")

  // No result right out of reset
  `PCGB_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !out_valid, "result valid after reset")

  // Invalid bounds always report all ones
  `PCGB_ASSERT(a_invalid_val, out_valid && out_invalid |-> out_value == -32'sd1, "invalid result not -1")

  // An accepted request keeps the block busy on the next edge
  `PCGB_ASSERT(a_busy_after, in_valid && !in_stall |=> in_stall, "request taken back to back")

endmodule

bind pcg32_bounded_random pcg32_bounded_random_checker u_checker (.*);

`default_nettype wire
